FILE: src/lgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the life generation stepper
// Grid size defaults, item mode codes, register indexes and rule constants.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // size registers and APB port
  localparam int SIZE_W   = 7;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // item mode codes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // B3/S23 neighbor counts
  localparam int         CNT_W      = 4;
  localparam logic [3:0] CNT_SURVIVE = 4'd2;
  localparam logic [3:0] CNT_BIRTH   = 4'd3;

  // active region, already clamped to 1..MAX
  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
  } size_t;

endpackage

FILE: src/lgs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = lgs_pkg::MAX_COLS_DEF,
  parameter int DEPTH = lgs_pkg::MAX_ROWS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lgs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cfg: APB register block
// Holds rows_in_use and cols_in_use, hands out the clamped region size.
// ----------------------------------------------------------------------------
module lgs_cfg #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lgs_pkg::PADDR_W-1:0]  paddr,
  input  logic [lgs_pkg::DATA_W-1:0]   pwdata,
  output logic [lgs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output lgs_pkg::size_t               size_o
);

  localparam int SW = lgs_pkg::SIZE_W;
  localparam logic [SW-1:0] RESET_SIZE = SW'(64);

  logic [SW-1:0] rows_q, cols_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RESET_SIZE;
      cols_q <= RESET_SIZE;
    end else if (wr_en) begin
      case (paddr[2])
        lgs_pkg::REG_ROWS: rows_q <= pwdata[SW-1:0];
        lgs_pkg::REG_COLS: cols_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lgs_pkg::REG_ROWS: prdata = {{(lgs_pkg::DATA_W-SW){1'b0}}, rows_q};
      lgs_pkg::REG_COLS: prdata = {{(lgs_pkg::DATA_W-SW){1'b0}}, cols_q};
      default:           prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (rows_q == '0) begin
      size_o.rows = SW'(1);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      size_o.rows = SW'(MAX_ROWS);
    end else begin
      size_o.rows = rows_q;
    end
    if (cols_q == '0) begin
      size_o.cols = SW'(1);
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      size_o.cols = SW'(MAX_COLS);
    end else begin
      size_o.cols = cols_q;
    end
  end

endmodule

FILE: src/lgs_row_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_row_calc: next generation of one grid row
// One lane per column; columns wrap at cols_i, columns beyond it hold.
// ----------------------------------------------------------------------------
module lgs_row_calc #(
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic [MAX_COLS-1:0]        above_i,
  input  logic [MAX_COLS-1:0]        cur_i,
  input  logic [MAX_COLS-1:0]        below_i,
  input  logic [lgs_pkg::SIZE_W-1:0] cols_i,
  output logic [MAX_COLS-1:0]        next_o
);

  localparam int CA = $clog2(MAX_COLS);
  localparam int CW = lgs_pkg::CNT_W;

  logic [CA-1:0] last_idx;
  logic          a_last, c_last, b_last;

  assign last_idx = CA'(cols_i - lgs_pkg::SIZE_W'(1));
  assign a_last   = above_i[last_idx];
  assign c_last   = cur_i[last_idx];
  assign b_last   = below_i[last_idx];

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_lane
    logic          al, cl, bl, ar, cr, br, at_right;
    logic [CW-1:0] cnt;

    // left neighbor column
    if (j == 0) begin : g_left_wrap
      assign al = a_last;
      assign cl = c_last;
      assign bl = b_last;
    end else begin : g_left
      assign al = above_i[j-1];
      assign cl = cur_i[j-1];
      assign bl = below_i[j-1];
    end

    // right neighbor column, wraps to column 0 at the region edge
    assign at_right = ((32'(j) + 32'd1) == 32'(cols_i));
    if (j == MAX_COLS - 1) begin : g_right_wrap
      assign ar = above_i[0];
      assign cr = cur_i[0];
      assign br = below_i[0];
    end else begin : g_right
      assign ar = at_right ? above_i[0] : above_i[j+1];
      assign cr = at_right ? cur_i[0]   : cur_i[j+1];
      assign br = at_right ? below_i[0] : below_i[j+1];
    end

    assign cnt = CW'(al) + CW'(above_i[j]) + CW'(ar) + CW'(cl) + CW'(cr)
               + CW'(bl) + CW'(below_i[j]) + CW'(br);

    always_comb begin
      if (32'(cols_i) > 32'(j)) begin
        next_o[j] = (cnt == lgs_pkg::CNT_BIRTH) ||
                    ((cnt == lgs_pkg::CNT_SURVIVE) && cur_i[j]);
      end else begin
        next_o[j] = cur_i[j];
      end
    end
  end

endmodule

FILE: src/life_generation_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stepper: toroidal B3/S23 grid of one-bit cells
// Row-wide grid RAM with a three-row window that steps the grid in place.
// ----------------------------------------------------------------------------
// The grid lives in one RAM of MAX_ROWS words, each word one full row of
// MAX_COLS cells, with one read and one write port and a registered read.
// After reset the block runs a clearing pass, one row per cycle, with
// in_stall_o high; APB writes are taken during it. A load beat reads the
// row, then writes the patched row back; outside the region it is dropped
// at once. A read beat reads the row and then waits while the output
// register is still held by out_stall_i. A step beat makes one RAM read
// and one write per row through the single read port and write port.
// The region is rows_in_use x cols_in_use (0 reads as 1, oversize as the
// maximum); rows and columns outside it are left alone by a step, loads
// outside are dropped and reads outside return 0. Mode 3 is a no-op.
// Configuration should only be written while the block is idle.
// ----------------------------------------------------------------------------
module life_generation_stepper #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   mode_i,
  input  logic [5:0]                   row_i,
  input  logic [5:0]                   col_i,
  input  logic                         cell_in_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         cell_out_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lgs_pkg::PADDR_W-1:0]  paddr,
  input  logic [lgs_pkg::DATA_W-1:0]   pwdata,
  output logic [lgs_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int RA = $clog2(MAX_ROWS);
  localparam int CA = $clog2(MAX_COLS);
  localparam int SW = lgs_pkg::SIZE_W;

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_LD_WAIT = 8'b0000_0100,
    ST_RD_WAIT = 8'b0000_1000,
    ST_SP_TOP  = 8'b0001_0000,
    ST_SP_CUR  = 8'b0010_0000,
    ST_SP_BOT  = 8'b0100_0000,
    ST_SP_ROW  = 8'b1000_0000
  } state_e;

  state_e         state_q, state_d;
  logic [SW-1:0]  row_q, row_d;      // item row, or step row counter
  logic [RA-1:0]  clr_q, clr_d;
  logic           out_valid_q, out_valid_d;
  logic           cell_out_q;
  logic           out_load;

  lgs_pkg::size_t size;

  // step window and item payload
  logic [MAX_COLS-1:0] above_q, cur_q, below_q, row0_q;
  logic                wrap0_q, wrap0_d;
  logic [5:0]          col_q;
  logic                cell_q, hit_q;

  logic                ram_we, ram_re;
  logic [RA-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;
  logic [MAX_COLS-1:0] next_row, patched_row;

  logic                in_region, rd_bit, last_row;
  logic [SW:0]         row_plus2;

  lgs_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  lgs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lgs_row_calc #(
    .MAX_COLS (MAX_COLS)
  ) u_calc (
    .above_i (above_q),
    .cur_i   (cur_q),
    .below_i (below_q),
    .cols_i  (size.cols),
    .next_o  (next_row)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;

  assign in_region = ({1'b0, row_i} < size.rows) && ({1'b0, col_i} < size.cols);
  assign last_row  = (row_q == SW'(size.rows - SW'(1)));
  assign row_plus2 = {1'b0, row_q} + (SW+1)'(2);
  assign rd_bit    = hit_q ? ram_rdata[CA'(col_q)] : 1'b0;

  // load: replace one cell of the row just read
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      patched_row[j] = (32'(col_q) == 32'(j)) ? cell_q : ram_rdata[j];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    clr_d       = clr_q;
    wrap0_d     = wrap0_q;
    ram_we      = 1'b0;
    ram_waddr   = RA'(row_q);
    ram_wdata   = next_row;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    out_load    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == RA'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + RA'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            lgs_pkg::MODE_LOAD: begin
              if (in_region) begin
                ram_re    = 1'b1;
                ram_raddr = RA'(row_i);
                row_d     = SW'(row_i);
                state_d   = ST_LD_WAIT;
              end
            end
            lgs_pkg::MODE_READ: begin
              ram_re    = 1'b1;
              ram_raddr = RA'(row_i);
              state_d   = ST_RD_WAIT;
            end
            lgs_pkg::MODE_STEP: begin
              ram_re    = 1'b1;
              ram_raddr = RA'(size.rows - SW'(1));
              row_d     = '0;
              state_d   = ST_SP_TOP;
            end
            default: ;
          endcase
        end
      end
      ST_LD_WAIT: begin
        ram_we    = 1'b1;
        ram_wdata = patched_row;
        state_d   = ST_IDLE;
      end
      ST_RD_WAIT: begin
        // read data holds in the RAM register until the result slot frees
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_SP_TOP: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = ST_SP_CUR;
      end
      ST_SP_CUR: begin
        // single-row region: the row below is row 0 itself
        ram_re    = 1'b1;
        ram_raddr = (size.rows == SW'(1)) ? '0 : RA'(1);
        wrap0_d   = (size.rows == SW'(1));
        state_d   = ST_SP_BOT;
      end
      ST_SP_BOT: begin
        state_d = ST_SP_ROW;
      end
      ST_SP_ROW: begin
        ram_we = 1'b1;
        if (last_row) begin
          state_d = ST_IDLE;
        end else begin
          // row 0 has been overwritten; its old copy sits in row0_q
          wrap0_d   = (row_plus2 == {1'b0, size.rows});
          ram_re    = 1'b1;
          ram_raddr = RA'(row_plus2);
          row_d     = row_q + SW'(1);
          state_d   = ST_SP_BOT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      clr_q       <= '0;
      wrap0_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      clr_q       <= clr_d;
      wrap0_q     <= wrap0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window and payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_out_q <= rd_bit;
    end
    case (state_q)
      ST_IDLE: begin
        col_q  <= col_i;
        cell_q <= cell_in_i;
        hit_q  <= in_region;
      end
      ST_SP_TOP: begin
        above_q <= ram_rdata;
      end
      ST_SP_CUR: begin
        cur_q  <= ram_rdata;
        row0_q <= ram_rdata;
      end
      ST_SP_BOT: begin
        below_q <= wrap0_q ? row0_q : ram_rdata;
      end
      ST_SP_ROW: begin
        above_q <= cur_q;
        cur_q   <= below_q;
      end
      default: ;
    endcase
  end

  // a new result only ever comes out of a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RD_WAIT))
    else $error("result raised outside a read");

  // a step never writes a row outside the region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SP_ROW) |-> (row_q < size.rows))
    else $error("step row counter beyond rows in use");

  // a step ends only after the last row of the region is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SP_ROW && state_d == ST_IDLE) |-> last_row && ram_we)
    else $error("step ended early");

  // the result slot is never overwritten while still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("held result overwritten");

endmodule
